@@ rtl/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, S-box table and round functions for the AES encryptor.
// ----------------------------------------------------------------------------
package aes_pkg;

  typedef enum logic [1:0] {
    RND_ARK,
    RND_FULL,
    RND_FINAL,
    RND_PASS
  } rnd_mode_t;

  typedef struct packed {
    logic valid;
    logic err;
  } stage_ctl_t;

  typedef struct packed {
    logic ready;
    logic busy;
  } ks_stat_t;

  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_KEY1 = 3'd1;
  localparam logic [2:0] CFG_KEY2 = 3'd2;
  localparam logic [2:0] CFG_KEY3 = 3'd3;
  localparam logic [2:0] CFG_NK   = 3'd4;

  localparam logic [3:0] NK_128 = 4'd4;
  localparam logic [3:0] NK_192 = 4'd6;
  localparam logic [3:0] NK_256 = 4'd8;

  localparam int NUM_STAGES = 15;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    logic [31:0] o;
    for (int k = 0; k < 4; k++) begin
      o[8*k +: 8] = SBOX[w[8*k +: 8]];
    end
    return o;
  endfunction

  // byte k of the state sits at bits 127-8k downto 120-8k
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*((c+r)&3)+r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, d0, d1, d2, d3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      d0 = xtime(a0);
      d1 = xtime(a1);
      d2 = xtime(a2);
      d3 = xtime(a3);
      t[127-32*c -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
      t[111-32*c -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
      t[103-32*c -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end
    return t;
  endfunction

endpackage

@@ rtl/aes_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// aes_block_encrypt
// AES-128/192/256 forward cipher, one round per pipeline stage.
// ----------------------------------------------------------------------------
//  channel  direction  signals                        content
//  s_*      in         s_tvalid s_tready s_tdata      plaintext block
//  m_*      out        m_tvalid m_tready m_tdata      ciphertext block
//                      m_tuser                        key error flag
//  cfg_*    in         cfg_valid cfg_ready            register write
//                      cfg_index cfg_data
//
//  Fifteen register stages (initial key add, then one per round); a block
//  can enter every cycle while the output does not stall and the key
//  schedule is ready. Shorter keys pass through the surplus stages
//  unchanged. After reset or a write to a key or length register, with a
//  valid Nk, the key schedule is rebuilt before the next block: a start
//  step, then 4*(Nk+7) words, one per cycle, input held off meanwhile.
//  A stall at the output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module aes_block_encrypt
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // block_upper[63:0], block_lower[127:64]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // cipher_upper[63:0], cipher_lower[127:64]
  output logic         m_tuser,   // key_error
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [3:0][63:0]             key;
  logic [3:0]                   nk;
  logic                         nk_ok;
  logic                         cfg_wr;
  logic                         en;
  logic [4:0]                   nr;
  ks_stat_t                     ks;
  logic [NUM_STAGES-1:0][127:0] round_keys;
  stage_ctl_t                   ctl [NUM_STAGES+1];
  logic [127:0]                 dat [NUM_STAGES+1];
  rnd_mode_t                    mode [NUM_STAGES];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign nk_ok     = (nk == NK_128) || (nk == NK_192) || (nk == NK_256);
  assign nr        = {1'b0, nk} + 5'd6;

  // key and length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      nk  <= NK_256;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_KEY0: key[0] <= cfg_data;
        CFG_KEY1: key[1] <= cfg_data;
        CFG_KEY2: key[2] <= cfg_data;
        CFG_KEY3: key[3] <= cfg_data;
        CFG_NK:   nk     <= cfg_data[3:0];
        default:  ;
      endcase
    end
  end

  // writes beyond the register list leave the schedule alone
  aes_key_expand u_key_expand (
    .clk        (clk),
    .rst        (rst),
    .clr        (cfg_wr && cfg_index <= CFG_NK),
    .start      (nk_ok && !ks.ready),
    .nk         (nk),
    .key        (key),
    .stat       (ks),
    .round_keys (round_keys)
  );

  // global advance; last stage doubles as the output register
  assign en       = !ctl[NUM_STAGES].valid || m_tready;
  assign s_tready = en && (!nk_ok || ks.ready);

  assign ctl[0] = '{valid: s_tvalid && s_tready, err: !nk_ok};
  assign dat[0] = {s_tdata[63:0], s_tdata[127:64]};

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    always_comb begin
      if (g == 0) begin
        mode[g] = RND_ARK;
      end else if (5'(g) < nr) begin
        mode[g] = RND_FULL;
      end else if (5'(g) == nr) begin
        mode[g] = RND_FINAL;
      end else begin
        mode[g] = RND_PASS;
      end
    end

    aes_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .mode      (mode[g]),
      .round_key (round_keys[g]),
      .ctl_in    (ctl[g]),
      .state_in  (dat[g]),
      .ctl_out   (ctl[g+1]),
      .state_out (dat[g+1])
    );
  end

  assign m_tvalid = ctl[NUM_STAGES].valid;
  assign m_tuser  = ctl[NUM_STAGES].err;
  assign m_tdata  = ctl[NUM_STAGES].err ? '0
                  : {dat[NUM_STAGES][63:0], dat[NUM_STAGES][127:64]};

  a_no_block_before_schedule: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && nk_ok) |-> (ks.ready && !ks.busy))
    else $error("block accepted without a ready key schedule");

  a_write_clears_schedule: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && cfg_index <= CFG_NK) |=> !ks.ready)
    else $error("key schedule still marked ready after a write");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("key error result carries data");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(ctl[1].valid)))
    else $error("pipeline moved during output stall");

endmodule

@@ rtl/aes_round.sv @@
// ----------------------------------------------------------------------------
// aes_round
// One registered pipeline stage: key add, full round, final round or pass.
// ----------------------------------------------------------------------------
module aes_round
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  rnd_mode_t    mode,
  input  logic [127:0] round_key,
  input  stage_ctl_t   ctl_in,
  input  logic [127:0] state_in,
  output stage_ctl_t   ctl_out,
  output logic [127:0] state_out
);

  logic [127:0] state_next;

  always_comb begin
    case (mode)
      RND_ARK:   state_next = state_in ^ round_key;
      RND_FULL:  state_next = mix(sub_shift(state_in)) ^ round_key;
      RND_FINAL: state_next = sub_shift(state_in) ^ round_key;
      default:   state_next = state_in;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_out <= state_next;
    end
  end

endmodule

@@ rtl/aes_key_expand.sv @@
// ----------------------------------------------------------------------------
// aes_key_expand
// Key schedule, one 32-bit word per cycle, into per-round key registers.
// ----------------------------------------------------------------------------
module aes_key_expand
  import aes_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clr,
  input  logic                          start,
  input  logic [3:0]                    nk,
  input  logic [3:0][63:0]              key,
  output ks_stat_t                      stat,
  output logic [NUM_STAGES-1:0][127:0]  round_keys
);

  logic [5:0]       idx;
  logic [2:0]       phase;   // idx mod nk
  logic [7:0]       rc;
  logic [7:0][31:0] win;     // win[0] is the newest word
  logic [31:0]      word, temp, far_word;
  logic [63:0]      kreg;
  logic [5:0]       last_idx;

  assign last_idx = {nk, 2'b00} + 6'd27;
  assign kreg     = key[idx[2:1]];

  always_comb begin
    case (nk)
      NK_128:  far_word = win[3];
      NK_192:  far_word = win[5];
      default: far_word = win[7];
    endcase
    temp = win[0];
    if (phase == 3'd0) begin
      temp = subst_word({win[0][23:0], win[0][31:24]}) ^ {rc, 24'd0};
    end else if (nk == NK_256 && phase == 3'd4) begin
      temp = subst_word(win[0]);
    end
    if (idx < {2'b00, nk}) begin
      word = idx[0] ? kreg[31:0] : kreg[63:32];
    end else begin
      word = far_word ^ temp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      stat <= '0;
    end else if (stat.busy) begin
      if (idx == last_idx) begin
        stat <= '{ready: 1'b1, busy: 1'b0};
      end
    end else if (start) begin
      stat.busy <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!stat.busy) begin
      idx   <= '0;
      phase <= '0;
      rc    <= 8'h01;
    end else begin
      idx   <= idx + 6'd1;
      phase <= (phase == 3'(nk - 4'd1)) ? 3'd0 : phase + 3'd1;
      if (phase == 3'd0 && idx >= {2'b00, nk}) begin
        rc <= xtime(rc);
      end
      win <= {win[6:0], word};
      round_keys[idx[5:2]][{~idx[1:0], 5'b0} +: 32] <= word;
    end
  end

endmodule
